/* hw/rtl/priority_ready_queue_manager_unit_macros.svh */
// Assertion macros shared by the ready-queue manager RTL.
// Depends on clk and rst_n being visible at the point of use.
`ifndef PRIORITY_READY_QUEUE_MANAGER_UNIT_MACROS_SVH
`define PRIORITY_READY_QUEUE_MANAGER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PRQM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PRQM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/prqm_pkg.sv */
// Package for the priority ready-queue manager: field widths, command and
// status codes. No dependencies.
package prqm_pkg;

  localparam int CMD_W      = 2;
  localparam int QID_W      = 8;
  localparam int NODE_W     = 6;
  localparam int STATUS_W   = 3;
  localparam int CNT_W      = 7;
  localparam int LVL_W      = 5;
  localparam int NODE_SPACE = 2 ** NODE_W;
  localparam int MAX_QUEUES = 'h20;

  typedef enum logic [CMD_W-1:0] {
    CMD_QUERY = 2'd0,
    CMD_ENQ   = 2'd1,
    CMD_DEQ   = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_QUEUED = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_NOT_IN = 3'd3,
    ST_BAD_Q  = 3'd4
  } status_t;

endpackage

/* hw/rtl/prqm_ifs.sv */
// Valid/ready channel interfaces for the command and result streams.
// Depends on prqm_pkg.
interface prqm_in_if
  import prqm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [QID_W-1:0]  level_id;
  logic [NODE_W-1:0] node_id;
  logic              at_head;

  modport source (output valid, cmd, level_id, node_id, at_head, input ready);
  modport sink   (input valid, cmd, level_id, node_id, at_head, output ready);
endinterface

interface prqm_out_if
  import prqm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [NODE_W-1:0]   head_node;
  logic                head_valid;
  logic [CNT_W-1:0]    queue_count;
  logic [LVL_W-1:0]    lowest_ready;
  logic                any_ready;

  modport source (output valid, status, head_node, head_valid, queue_count,
                  lowest_ready, any_ready, input ready);
  modport sink   (input valid, status, head_node, head_valid, queue_count,
                  lowest_ready, any_ready, output ready);
endinterface

/* hw/rtl/priority_ready_queue_manager_unit.sv */
// Priority ready-queue manager, top level. Uses prqm_pkg, prqm_ifs, prqm_ram.
// Path: a command transfer reads the link memories into stage 1, then the update logic
// writes the result register; a stalled result holds the command in stage 1.
// Throughput: one command per cycle; two commands in flight fill it, and a stalled
// result then holds the input. Each command does at most one write per link memory.
// Reset (sync, rst_n low): clears bitmap, lengths, queued flags and valids.
`include "priority_ready_queue_manager_unit_macros.svh"

module priority_ready_queue_manager_unit
  import prqm_pkg::*;
#(
  parameter int NUM_QUEUES = 32,  // 2 .. MAX_QUEUES
  parameter int NUM_NODES  = 64   // 2 .. 256, ids above NODE_SPACE never occur
) (
  input logic        clk,
  input logic        rst_n,
  prqm_in_if.sink    in_ch,
  prqm_out_if.source out_ch
);

  localparam int QAW        = $clog2(NUM_QUEUES);
  localparam int NODE_DEPTH = (NUM_NODES < NODE_SPACE) ? NUM_NODES : NODE_SPACE;
  localparam int NAW        = $clog2(NODE_DEPTH);

  // ---------------------------------------------------------------------------
  // Handshake and pipeline control
  // ---------------------------------------------------------------------------
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_adv;
  logic commit;
  logic accept;
  logic in_ready;

  // Stage 1 advances whenever the result register is free or being drained.
  assign s1_adv   = !out_valid_r || out_ch.ready;
  assign commit   = s1_valid_r && s1_adv;
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (commit) begin
        s1_valid_r <= 1'b0;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 command register
  // ---------------------------------------------------------------------------
  logic [CMD_W-1:0]  cmd_r;
  logic [QID_W-1:0]  level_id_r;
  logic [NODE_W-1:0] node_id_r;
  logic              at_head_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r      <= in_ch.cmd;
      level_id_r <= in_ch.level_id;
      node_id_r  <= in_ch.node_id;
      at_head_r  <= in_ch.at_head;
    end
  end

  // ---------------------------------------------------------------------------
  // Per-level and per-node state held in flops
  // ---------------------------------------------------------------------------
  logic [NUM_QUEUES-1:0] ready_r;
  logic [NUM_QUEUES-1:0] ready_nxt;
  logic [CNT_W-1:0]      len_r    [NUM_QUEUES];
  logic [NODE_W-1:0]     head_r   [NUM_QUEUES];
  logic [NODE_W-1:0]     tail_r   [NUM_QUEUES];
  logic [NODE_DEPTH-1:0] queued_r;

  // ---------------------------------------------------------------------------
  // Node link memories: next, prev and level, all read at the command's node
  // ---------------------------------------------------------------------------
  logic              next_we;
  logic [NAW-1:0]    next_waddr;
  logic [NODE_W-1:0] next_wdata;
  logic [NODE_W-1:0] next_rdata;
  logic              prev_we;
  logic [NAW-1:0]    prev_waddr;
  logic [NODE_W-1:0] prev_wdata;
  logic [NODE_W-1:0] prev_rdata;
  logic              lvl_we;
  logic [QAW-1:0]    lvl_rdata;
  logic [NAW-1:0]    rd_addr;
  logic [NAW-1:0]    ni;
  logic [QAW-1:0]    qi;

  assign rd_addr = in_ch.node_id[NAW-1:0];

  prqm_ram #(.WIDTH(NODE_W), .DEPTH(NODE_DEPTH)) u_next_ram (
    .clk   (clk),
    .we    (commit && next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (next_rdata)
  );

  prqm_ram #(.WIDTH(NODE_W), .DEPTH(NODE_DEPTH)) u_prev_ram (
    .clk   (clk),
    .we    (commit && prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (prev_rdata)
  );

  prqm_ram #(.WIDTH(QAW), .DEPTH(NODE_DEPTH)) u_lvl_ram (
    .clk   (clk),
    .we    (commit && lvl_we),
    .waddr (ni),
    .wdata (qi),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (lvl_rdata)
  );

  // The read issued at a transfer misses a write committed on the same edge;
  // capture that write here and use it in place of the memory data.
  logic              fwd_next_hit_r;
  logic              fwd_prev_hit_r;
  logic              fwd_lvl_hit_r;
  logic [NODE_W-1:0] fwd_next_r;
  logic [NODE_W-1:0] fwd_prev_r;
  logic [QAW-1:0]    fwd_lvl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_next_hit_r <= 1'b0;
      fwd_prev_hit_r <= 1'b0;
      fwd_lvl_hit_r  <= 1'b0;
    end else if (accept) begin
      fwd_next_hit_r <= commit && next_we && (next_waddr == rd_addr);
      fwd_prev_hit_r <= commit && prev_we && (prev_waddr == rd_addr);
      fwd_lvl_hit_r  <= commit && lvl_we && (ni == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_next_r <= next_wdata;
      fwd_prev_r <= prev_wdata;
      fwd_lvl_r  <= qi;
    end
  end

  // ---------------------------------------------------------------------------
  // Command evaluation and list update
  // ---------------------------------------------------------------------------
  logic              q_ok;
  logic              n_ok;
  logic              queued;
  logic [CNT_W-1:0]  cur_len;
  logic [NODE_W-1:0] cur_head;
  logic [NODE_W-1:0] cur_tail;
  logic [NODE_W-1:0] nnext;
  logic [NODE_W-1:0] nprev;
  logic [QAW-1:0]    nlevel;
  logic              is_head;
  logic              is_tail;
  logic              do_link;
  logic              do_unlink;
  status_t           status;
  logic [CNT_W-1:0]  q_len_nxt;
  logic [NODE_W-1:0] q_head_nxt;
  logic [NODE_W-1:0] q_tail_nxt;
  logic [CNT_W-1:0]  res_cnt;
  logic              res_hv;
  logic [NODE_W-1:0] res_hn;
  logic [LVL_W-1:0]  res_low;
  logic              res_any;

  assign q_ok     = int'(level_id_r) < NUM_QUEUES;
  assign n_ok     = int'(node_id_r) < NUM_NODES;
  assign qi       = level_id_r[QAW-1:0];
  assign ni       = node_id_r[NAW-1:0];
  assign cur_len  = len_r[qi];
  assign cur_head = head_r[qi];
  assign cur_tail = tail_r[qi];
  assign queued   = n_ok && queued_r[ni];
  assign nnext    = fwd_next_hit_r ? fwd_next_r : next_rdata;
  assign nprev    = fwd_prev_hit_r ? fwd_prev_r : prev_rdata;
  assign nlevel   = fwd_lvl_hit_r ? fwd_lvl_r : lvl_rdata;
  assign is_head  = cur_head == node_id_r;
  assign is_tail  = cur_tail == node_id_r;

  // Decide status; a bad level id rejects every command, unused code = query.
  always_comb begin
    status    = ST_OK;
    do_link   = 1'b0;
    do_unlink = 1'b0;
    if (!q_ok) begin
      status = ST_BAD_Q;
    end else begin
      case (cmd_r)
        CMD_ENQ: begin
          if (!n_ok) begin
            status = ST_NOT_IN;
          end else if (queued) begin
            status = ST_QUEUED;
          end else begin
            do_link = 1'b1;
          end
        end
        CMD_DEQ: begin
          if (cur_len == '0) begin
            status = ST_EMPTY;
          end else if (!queued || (nlevel != qi)) begin
            status = ST_NOT_IN;
          end else begin
            do_unlink = 1'b1;
          end
        end
        default: begin
          if (cur_len == '0) begin
            status = ST_EMPTY;
          end
        end
      endcase
    end
  end

  // Link or unlink the node; at most one write per link memory.
  always_comb begin
    q_len_nxt  = cur_len;
    q_head_nxt = cur_head;
    q_tail_nxt = cur_tail;
    next_we    = 1'b0;
    next_waddr = ni;
    next_wdata = cur_head;
    prev_we    = 1'b0;
    prev_waddr = ni;
    prev_wdata = cur_tail;
    lvl_we     = 1'b0;
    if (do_link) begin
      q_len_nxt = cur_len + CNT_W'(1);
      lvl_we    = 1'b1;
      if (cur_len == '0) begin
        q_head_nxt = node_id_r;
        q_tail_nxt = node_id_r;
      end else if (at_head_r) begin
        next_we    = 1'b1;
        prev_we    = 1'b1;
        prev_waddr = cur_head[NAW-1:0];
        prev_wdata = node_id_r;
        q_head_nxt = node_id_r;
      end else begin
        prev_we    = 1'b1;
        next_we    = 1'b1;
        next_waddr = cur_tail[NAW-1:0];
        next_wdata = node_id_r;
        q_tail_nxt = node_id_r;
      end
    end else if (do_unlink) begin
      q_len_nxt = cur_len - CNT_W'(1);
      if (is_head && !is_tail) begin
        q_head_nxt = nnext;
      end else if (is_tail && !is_head) begin
        q_tail_nxt = nprev;
      end else if (!is_head && !is_tail) begin
        // Middle node: bridge its neighbors.
        next_we    = 1'b1;
        next_waddr = nprev[NAW-1:0];
        next_wdata = nnext;
        prev_we    = 1'b1;
        prev_waddr = nnext[NAW-1:0];
        prev_wdata = nprev;
      end
    end
  end

  always_comb begin
    ready_nxt = ready_r;
    if (do_link || do_unlink) begin
      ready_nxt[qi] = q_len_nxt != '0;
    end
  end

  // Lowest non-empty level after this command.
  always_comb begin
    res_low = '0;
    res_any = 1'b0;
    for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
      if (ready_nxt[i]) begin
        res_low = LVL_W'(i);
        res_any = 1'b1;
      end
    end
  end

  assign res_cnt = q_ok ? q_len_nxt : '0;
  assign res_hv  = res_cnt != '0;
  assign res_hn  = res_hv ? q_head_nxt : '0;

  // ---------------------------------------------------------------------------
  // State commit
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r  <= '0;
      queued_r <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        len_r[i] <= '0;
      end
    end else if (commit && (do_link || do_unlink)) begin
      ready_r      <= ready_nxt;
      len_r[qi]    <= q_len_nxt;
      queued_r[ni] <= do_link;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && (do_link || do_unlink)) begin
      head_r[qi] <= q_head_nxt;
      tail_r[qi] <= q_tail_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic [STATUS_W-1:0] out_status_r;
  logic [NODE_W-1:0]   out_head_node_r;
  logic                out_head_valid_r;
  logic [CNT_W-1:0]    out_count_r;
  logic [LVL_W-1:0]    out_low_r;
  logic                out_any_r;

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status_r     <= status;
      out_head_node_r  <= res_hn;
      out_head_valid_r <= res_hv;
      out_count_r      <= res_cnt;
      out_low_r        <= res_low;
      out_any_r        <= res_any;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.head_node    = out_head_node_r;
  assign out_ch.head_valid   = out_head_valid_r;
  assign out_ch.queue_count  = out_count_r;
  assign out_ch.lowest_ready = out_low_r;
  assign out_ch.any_ready    = out_any_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `PRQM_ASSERT_IMPL(a_ready_matches_len, s1_valid_r && q_ok,
                    ready_r[qi] == (len_r[qi] != '0),
                    "ready bit disagrees with level length")
  `PRQM_ASSERT_NEXT(a_link_reports_ok, commit && do_link,
                    out_valid_r && (out_status_r == ST_OK) && out_head_valid_r,
                    "enqueue result not ok or level empty")
  `PRQM_ASSERT_IMPL(a_hold_when_full, s1_valid_r && out_valid_r && !out_ch.ready,
                    !in_ready,
                    "transfer taken while pipeline is full")
  `PRQM_ASSERT_NEXT(a_bad_queue_no_change, commit && !q_ok,
                    $stable(ready_r) && $stable(queued_r),
                    "bad level id changed state")

endmodule

/* hw/rtl/prqm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Read-first on a same-address collision. No dependencies.
module prqm_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
